// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL modules that carry checks.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_IMPLIES(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/ls_unesc_pkg.sv =====
// Package for the literal string unescaper: character codes, result type
// and result queue sizing. No dependencies.
package ls_unesc_pkg;

    localparam int NEST_BITS  = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_end;
        logic       end_kind;
        logic       run_last;
    } result_t;

endpackage

// ===== hw/rtl/literal_string_unescaper.sv =====
// Literal string unescaper: decodes a parenthesized, escaped byte string.
// Depends on ls_unesc_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, in_byte, data_end) carries one raw byte
//   per request. While idle the block discards bytes until an opening
//   parenthesis, which opens a string. Inside the string it tracks nesting
//   depth, expands escapes and octal codes, and emits decoded bytes.
//   Output channel (out_valid/out_ready) carries one result per request:
//   out_byte/byte_valid, string_end with end_kind on the final result of a
//   string (0 closed, 1 input ran out), and run_last on the final result of
//   each input byte. One input byte yields zero, one or two results.
//   Path: a byte is captured in the input register, then the decode step writes
//   its results into the result queue, from which they are offered; the decode
//   step waits while the queue lacks room. Throughput: one byte per cycle while
//   the queue has room; two-result bytes are limited by the single-result
//   output port, which drains one result per cycle while out_ready is high.
//   A four-entry result queue decouples the two sides: the decode step
//   advances whenever at least two entries are free, so the input keeps
//   flowing while a finished result waits. When the receiver stalls the
//   queue fills and in_ready drops until room returns.
//   Reset: returns to idle with depth and octal state cleared, queue empty.
module literal_string_unescaper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       data_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_end,
    output logic       end_kind,
    output logic       run_last
);
    import ls_unesc_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_CRLF,
        PH_OCT
    } phase_t;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       data_end_reg;

    // Decoder state
    phase_t               phase_reg, phase_next;
    logic [NEST_BITS-1:0] depth_reg, depth_next;
    logic [8:0]           oct_val_reg, oct_val_next;
    logic [1:0]           oct_dig_reg, oct_dig_next;

    // Result queue
    result_t             fifo_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    logic    advance;
    logic    pop;
    logic    [1:0] n_res;
    result_t res0, res1;

    assign advance  = in_valid_reg && (count_reg <= CNT_BITS'(FIFO_DEPTH - 2));
    assign in_ready = !in_valid_reg || advance;
    assign pop      = out_valid && out_ready;

    // Plain body byte: shared by body, line-continuation and octal-ending paths.
    logic                 c_is_oct;
    logic                 body_esc, body_close, body_emit;
    logic [NEST_BITS-1:0] depth_inc, depth_dec, body_depth;
    phase_t               body_phase;

    always_comb
    begin
        c_is_oct   = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_SEVEN);
        depth_inc  = (depth_reg != '1) ? depth_reg + 1'b1 : depth_reg;
        depth_dec  = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;
        body_esc   = (in_byte_reg == CH_BSLASH) && !data_end_reg;
        body_close = (in_byte_reg == CH_RPAREN) && (depth_dec == '0);
        body_emit  = !body_esc && !body_close;
        body_phase = body_esc ? PH_ESC : PH_BODY;
        if (in_byte_reg == CH_LPAREN)
        begin
            body_depth = depth_inc;
        end
        else if (in_byte_reg == CH_RPAREN)
        begin
            body_depth = depth_dec;
        end
        else
        begin
            body_depth = depth_reg;
        end
    end

    // Decode step
    logic       pre_emit, main_emit, tail_emit;
    logic [7:0] main_byte;
    logic       end_closed, end_ranout, item_live;
    logic [1:0] dig_inc;
    logic [8:0] oct_shift;

    always_comb
    begin
        phase_next   = phase_reg;
        depth_next   = depth_reg;
        oct_val_next = oct_val_reg;
        oct_dig_next = oct_dig_reg;
        pre_emit     = 1'b0;
        main_emit    = 1'b0;
        main_byte    = in_byte_reg;
        end_closed   = 1'b0;
        item_live    = 1'b1;
        dig_inc      = oct_dig_reg + 2'd1;
        oct_shift    = {oct_val_reg[5:0], in_byte_reg[2:0]};

        unique case (phase_reg)
            PH_BODY:
            begin
                phase_next = body_phase;
                depth_next = body_depth;
                main_emit  = body_emit;
                end_closed = body_close && !body_esc;
            end
            PH_ESC:
            begin
                phase_next = PH_BODY;
                unique case (in_byte_reg)
                    CH_N:
                    begin
                        main_emit = 1'b1;
                        main_byte = CH_LF;
                    end
                    CH_R:
                    begin
                        main_emit = 1'b1;
                        main_byte = CH_CR;
                    end
                    CH_T:
                    begin
                        main_emit = 1'b1;
                        main_byte = CH_TAB;
                    end
                    CH_B:
                    begin
                        main_emit = 1'b1;
                        main_byte = CH_BS;
                    end
                    CH_F:
                    begin
                        main_emit = 1'b1;
                        main_byte = CH_FF;
                    end
                    CH_CR:
                    begin
                        phase_next = PH_CRLF;
                    end
                    CH_LF:
                    begin
                        phase_next = PH_BODY;
                    end
                    default:
                    begin
                        if (c_is_oct)
                        begin
                            oct_val_next = {6'd0, in_byte_reg[2:0]};
                            oct_dig_next = 2'd1;
                            phase_next   = PH_OCT;
                        end
                        else
                        begin
                            main_emit = 1'b1;
                        end
                    end
                endcase
            end
            PH_CRLF:
            begin
                if (in_byte_reg == CH_LF)
                begin
                    phase_next = PH_BODY;
                end
                else
                begin
                    phase_next = body_phase;
                    depth_next = body_depth;
                    main_emit  = body_emit;
                    end_closed = body_close && !body_esc;
                end
            end
            PH_OCT:
            begin
                if (c_is_oct)
                begin
                    // A third digit completes the code and flushes it at once.
                    if (dig_inc == 2'd3)
                    begin
                        main_emit    = 1'b1;
                        main_byte    = oct_shift[7:0];
                        oct_val_next = '0;
                        oct_dig_next = '0;
                        phase_next   = PH_BODY;
                    end
                    else
                    begin
                        oct_val_next = oct_shift;
                        oct_dig_next = dig_inc;
                    end
                end
                else
                begin
                    // Flush the pending code, then treat the byte as body text.
                    pre_emit     = 1'b1;
                    oct_val_next = '0;
                    oct_dig_next = '0;
                    phase_next   = body_phase;
                    depth_next   = body_depth;
                    main_emit    = body_emit;
                    end_closed   = body_close && !body_esc;
                end
            end
            default:
            begin
                if (in_byte_reg == CH_LPAREN)
                begin
                    depth_next   = NEST_BITS'(1);
                    oct_val_next = '0;
                    oct_dig_next = '0;
                    phase_next   = PH_BODY;
                end
                else
                begin
                    item_live = 1'b0;
                end
            end
        endcase

        end_ranout = item_live && !end_closed && data_end_reg;
        // Input ran out with an octal code still open: flush it.
        tail_emit  = end_ranout && (phase_next == PH_OCT);

        n_res = 2'(pre_emit) + 2'(main_emit) + 2'(tail_emit);

        res0 = '0;
        res1 = '0;
        if (pre_emit)
        begin
            res0.out_byte = oct_val_reg[7:0];
        end
        else if (main_emit)
        begin
            res0.out_byte = main_byte;
        end
        else
        begin
            res0.out_byte = oct_val_next[7:0];
        end
        res0.byte_valid = (n_res != 2'd0);
        res1.out_byte   = main_byte;
        res1.byte_valid = 1'b1;

        if (end_closed || end_ranout)
        begin
            if (n_res == 2'd0)
            begin
                n_res = 2'd1;
            end
            if (n_res == 2'd2)
            begin
                res1.string_end = 1'b1;
                res1.end_kind   = end_ranout;
            end
            else
            begin
                res0.string_end = 1'b1;
                res0.end_kind   = end_ranout;
            end
            phase_next   = PH_IDLE;
            depth_next   = '0;
            oct_val_next = '0;
            oct_dig_next = '0;
        end

        res0.run_last = (n_res == 2'd1);
        res1.run_last = 1'b1;
    end

    // Control state and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            depth_reg    <= '0;
            oct_val_reg  <= '0;
            oct_dig_reg  <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg   <= phase_next;
                depth_reg   <= depth_next;
                oct_val_reg <= oct_val_next;
                oct_dig_reg <= oct_dig_next;
                wr_ptr_reg  <= wr_ptr_reg + PTR_BITS'(n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (advance ? CNT_BITS'(n_res) : '0)
                         - CNT_BITS'(pop);
        end
    end

    // Payload: input register and result queue entries
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg  <= in_byte;
            data_end_reg <= data_end;
        end
        if (advance && (n_res != 2'd0))
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (advance && (n_res == 2'd2))
        begin
            fifo_mem[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    assign out_valid  = (count_reg != '0);
    assign out_byte   = fifo_mem[rd_ptr_reg].out_byte;
    assign byte_valid = fifo_mem[rd_ptr_reg].byte_valid;
    assign string_end = fifo_mem[rd_ptr_reg].string_end;
    assign end_kind   = fifo_mem[rd_ptr_reg].end_kind;
    assign run_last   = fifo_mem[rd_ptr_reg].run_last;

    // Checks
    `ASSERT_IMPLIES(a_queue_bound, clk, rst_n, 1'b1,
        count_reg <= CNT_BITS'(FIFO_DEPTH))
    `ASSERT_IMPLIES(a_end_is_last, clk, rst_n, out_valid && string_end, run_last)
    `ASSERT_IMPLIES(a_idle_clear, clk, rst_n, phase_reg == PH_IDLE,
        depth_reg == '0 && oct_dig_reg == '0 && oct_val_reg == '0)
    `ASSERT_IMPLIES(a_oct_digits, clk, rst_n, phase_reg == PH_OCT,
        oct_dig_reg == 2'd1 || oct_dig_reg == 2'd2)
    `ASSERT_NEXT(a_end_returns_idle, clk, rst_n,
        advance && (end_closed || end_ranout), phase_reg == PH_IDLE)

endmodule

// ===== tb/literal_string_unescaper_test.sv =====
// Self-checking testbench for literal_string_unescaper: directed and random
// byte streams against an in-bench decoder. Depends on ls_unesc_pkg and on
// the literal_string_unescaper RTL only.
module literal_string_unescaper_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ls_unesc_pkg::*;

    // Watchdog limit in cycles with no request moving on either channel.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 400;
    // Settling margin after the last predicted result, for stray late results.
    localparam int SETTLE_CYCLES  = 20;
    localparam logic [NEST_BITS-1:0] NEST_MAX = '1;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_BODY,
        SCAN_ESC,
        SCAN_CRLF,
        SCAN_OCT
    } scan_t;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_CLOSED,
        FIN_RANOUT
    } fin_t;

    // One raw input request; wait_drain holds it back until every predicted
    // result has come out.
    typedef struct packed {
        logic [7:0] raw;
        logic       last;
        logic       wait_drain;
    } raw_req_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       data_end = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       end_kind;
    logic       run_last;

    literal_string_unescaper dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .data_end   (data_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .string_end (string_end),
        .end_kind   (end_kind),
        .run_last   (run_last)
    );

    // Raw bytes waiting to be offered, and decoded results waiting to arrive.
    raw_req_t raw_pending_q[$];
    result_t  decoded_q[$];

    // Idle mix, set per phase by the sequencer.
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic holdoff_ask = 1'b0;
    int   holdoff_left;
    logic holdoff_done;

    int err_count = 0;
    int req_count = 0;
    int res_count = 0;
    int quiet_cycles = 0;

    // Decoder shadow state, advanced only by the driver on each accepted byte.
    scan_t                scan_st;
    logic [NEST_BITS-1:0] nest;
    logic [8:0]           oct_val;
    logic [1:0]           oct_cnt;
    logic [NEST_BITS-1:0] peak_nest = '0;
    result_t              step_res[2];
    int                   step_n;

    initial
    begin
        forever #5 clk = ~clk;
    end

    //------------------------------------------------------------------
    // Decoder prediction
    //------------------------------------------------------------------

    task automatic emit(input logic [7:0] b, input logic v);
        step_res[step_n] = '{out_byte: b, byte_valid: v, string_end: 1'b0,
                             end_kind: 1'b0, run_last: 1'b0};
        step_n++;
    endtask

    task automatic clear_scan();
        scan_st = SCAN_IDLE;
        nest    = '0;
        oct_val = '0;
        oct_cnt = '0;
    endtask

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    // Plain body byte: a backslash opens an escape unless it is the last
    // byte, parentheses move the depth, the closing one at depth one ends.
    task automatic plain_byte(input logic [7:0] c, input logic last, output fin_t fin);
        fin = FIN_NONE;
        scan_st = SCAN_BODY;
        if (c == CH_BSLASH && !last)
        begin
            scan_st = SCAN_ESC;
        end
        else if (c == CH_LPAREN)
        begin
            // Saturate: the byte still goes out, the depth stays put.
            if (nest != NEST_MAX)
                nest++;
            emit(CH_LPAREN, 1'b1);
        end
        else if (c == CH_RPAREN)
        begin
            if (nest != '0)
                nest--;
            if (nest != '0)
                emit(CH_RPAREN, 1'b1);
            else
                fin = FIN_CLOSED;
        end
        else
        begin
            emit(c, 1'b1);
        end
    endtask

    // Advance the shadow decoder by one raw byte and queue its results.
    task automatic decode_byte(input logic [7:0] c, input logic last);
        fin_t fin;
        fin = FIN_NONE;
        step_n = 0;
        unique case (scan_st)
            SCAN_IDLE:
            begin
                // Drop anything before the opening parenthesis.
                if (c != CH_LPAREN)
                    return;
                nest    = NEST_BITS'(1);
                oct_val = '0;
                oct_cnt = '0;
                scan_st = SCAN_BODY;
            end
            SCAN_BODY:
            begin
                plain_byte(c, last, fin);
            end
            SCAN_ESC:
            begin
                scan_st = SCAN_BODY;
                unique case (c)
                    CH_N: emit(CH_LF, 1'b1);
                    CH_R: emit(CH_CR, 1'b1);
                    CH_T: emit(CH_TAB, 1'b1);
                    CH_B: emit(CH_BS, 1'b1);
                    CH_F: emit(CH_FF, 1'b1);
                    CH_CR: scan_st = SCAN_CRLF;
                    CH_LF:
                    begin
                        // Line continuation: drop the newline.
                    end
                    default:
                    begin
                        if (is_octal(c))
                        begin
                            oct_val = {6'b0, c[2:0]};
                            oct_cnt = 2'd1;
                            scan_st = SCAN_OCT;
                        end
                        else
                        begin
                            // Unknown escape: pass the character through.
                            emit(c, 1'b1);
                        end
                    end
                endcase
            end
            SCAN_CRLF:
            begin
                // Swallow one LF after a continued CR, else a normal byte.
                if (c == CH_LF)
                    scan_st = SCAN_BODY;
                else
                    plain_byte(c, last, fin);
            end
            SCAN_OCT:
            begin
                if (is_octal(c))
                begin
                    oct_val = {oct_val[5:0], c[2:0]};
                    oct_cnt++;
                    // Third digit: flush at once.
                    if (oct_cnt == 2'd3)
                    begin
                        emit(oct_val[7:0], 1'b1);
                        oct_val = '0;
                        oct_cnt = '0;
                        scan_st = SCAN_BODY;
                    end
                end
                else
                begin
                    // Flush the pending value, then handle the byte normally.
                    emit(oct_val[7:0], 1'b1);
                    oct_val = '0;
                    oct_cnt = '0;
                    plain_byte(c, last, fin);
                end
            end
            default:
            begin
                clear_scan();
            end
        endcase

        if (nest > peak_nest)
            peak_nest = nest;

        if (fin == FIN_NONE && last)
        begin
            if (scan_st == SCAN_OCT)
                emit(oct_val[7:0], 1'b1);
            fin = FIN_RANOUT;
        end

        if (fin != FIN_NONE)
        begin
            // A string end with no decoded byte still takes a result.
            if (step_n == 0)
                emit(8'h00, 1'b0);
            step_res[step_n-1].string_end = 1'b1;
            step_res[step_n-1].end_kind   = (fin == FIN_RANOUT);
            clear_scan();
        end

        if (step_n > 0)
            step_res[step_n-1].run_last = 1'b1;

        for (int i = 0; i < step_n; i++)
            decoded_q.insert(decoded_q.size(), step_res[i]);
    endtask

    //------------------------------------------------------------------
    // Driver: offer raw bytes from the pending queue, predict on accept
    //------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            data_end <= 1'b0;
            clear_scan();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(in_byte, data_end);
                req_count++;
            end
            // Hold the current request until it is taken; otherwise pick the
            // next one, idling at random or while a drain pause is pending.
            if (!in_valid || in_ready)
            begin
                if (raw_pending_q.size() != 0
                    && $urandom_range(99) >= send_idle_pct
                    && !(raw_pending_q[0].wait_drain && decoded_q.size() != 0))
                begin
                    in_valid <= 1'b1;
                    in_byte  <= raw_pending_q[0].raw;
                    data_end <= raw_pending_q[0].last;
                    void'(raw_pending_q.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Monitor: check each accepted result, drive out_ready
    //------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns, result %0d: %s", $time, res_count, what);
        err_count++;
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        got = '{out_byte, byte_valid, string_end, end_kind, run_last};
        res_count++;
        if (decoded_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result %02h valid %0b end %0b kind %0b last %0b",
                got.out_byte, got.byte_valid, got.string_end, got.end_kind, got.run_last));
            return;
        end
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.byte_valid !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %0b, want %0b", got.byte_valid,
                want.byte_valid));
        if (got.string_end !== want.string_end)
            report_mismatch($sformatf("string_end %0b, want %0b", got.string_end,
                want.string_end));
        if (got.end_kind !== want.end_kind)
            report_mismatch($sformatf("end_kind %0b, want %0b", got.end_kind, want.end_kind));
        if (got.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %0b, want %0b", got.run_last, want.run_last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            // One long hold-off on request, counted here; the sender keeps
            // offering so the result queue fills and in_ready drops.
            if (holdoff_ask && !holdoff_done)
            begin
                holdoff_left <= HOLDOFF_CYCLES;
                holdoff_done <= 1'b1;
                out_ready    <= 1'b0;
            end
            else if (holdoff_left != 0)
            begin
                holdoff_left <= holdoff_left - 1;
                out_ready    <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run if no request moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no request moved for %0d cycles", quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------

    task automatic push_req(input logic [7:0] b, input logic last, input logic drain = 1'b0);
        raw_req_t req;
        req = '{raw: b, last: last, wait_drain: drain};
        raw_pending_q.insert(raw_pending_q.size(), req);
    endtask

    // Any byte except the three that steer depth and escapes.
    function automatic logic [7:0] plain_rand();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CH_LPAREN || b == CH_RPAREN || b == CH_BSLASH)
            b = b ^ 8'h40;
        return b;
    endfunction

    // Backslash plus a random escape body: named letters, parentheses, a backslash,
    // continuations, one to three octal digits, or an arbitrary byte.
    task automatic push_escape();
        int pick;
        pick = $urandom_range(13);
        push_req(CH_BSLASH, 1'b0);
        case (pick)
            0: push_req(CH_N, 1'b0);
            1: push_req(CH_R, 1'b0);
            2: push_req(CH_T, 1'b0);
            3: push_req(CH_B, 1'b0);
            4: push_req(CH_F, 1'b0);
            5: push_req(CH_LPAREN, 1'b0);
            6: push_req(CH_RPAREN, 1'b0);
            7: push_req(CH_BSLASH, 1'b0);
            8: push_req(CH_CR, 1'b0);
            9:
            begin
                push_req(CH_CR, 1'b0);
                push_req(CH_LF, 1'b0);
            end
            10: push_req(CH_LF, 1'b0);
            11:
            begin
                repeat ($urandom_range(1, 3))
                    push_req(CH_ZERO | 8'($urandom_range(7)), 1'b0);
            end
            default: push_req(8'($urandom_range(255)), 1'b0);
        endcase
    endtask

    // Well-formed string with random content; mostly short, a few long.
    // Ends either balanced or with the input running out.
    task automatic gen_string(input logic drain);
        int   depth;
        int   toks;
        int   kind;
        logic ranout;
        ranout = ($urandom_range(9) == 0);
        toks = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(10);
        push_req(CH_LPAREN, 1'b0, drain);
        depth = 1;
        for (int t = 0; t < toks; t++)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                push_req(plain_rand(), 1'b0);
            end
            else if (kind < 50)
            begin
                push_req(CH_LPAREN, 1'b0);
                depth++;
            end
            else if (kind < 58 && depth > 1)
            begin
                push_req(CH_RPAREN, 1'b0);
                depth--;
            end
            else
            begin
                push_escape();
            end
        end
        if (ranout)
        begin
            // A trailing backslash now and then: it must come out literally.
            if ($urandom_range(3) == 0)
                push_req(CH_BSLASH, 1'b1);
            else
                push_req(8'($urandom_range(255)), 1'b1);
        end
        else
        begin
            repeat (depth - 1)
                push_req(CH_RPAREN, 1'b0);
            // The closing parenthesis wins over data_end on the same byte.
            push_req(CH_RPAREN, $urandom_range(7) == 0);
        end
    endtask

    // Broken string: raw random bytes, then a last byte to force idle.
    task automatic gen_broken();
        push_req(CH_LPAREN, 1'b0);
        repeat ($urandom_range(1, 12))
            push_req(8'($urandom_range(255)), $urandom_range(9) == 0);
        push_req(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic wait_accepted();
        while (raw_pending_q.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // Fill the pending queue with about quota counted requests under one
    // idle mix, then wait until the driver has handed them all over.
    task automatic run_random(input int idle_pct, input int stall_pct, input int quota);
        int made;
        int before_n;
        int pick;
        logic [7:0] b;
        send_idle_pct  <= idle_pct;
        recv_stall_pct <= stall_pct;
        made = 0;
        while (made < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                // Idle noise: never an opening parenthesis, so it is dropped
                // and does not count toward the quota.
                repeat ($urandom_range(1, 4))
                begin
                    b = 8'($urandom_range(255));
                    if (b == CH_LPAREN)
                        b = ~b;
                    push_req(b, $urandom_range(3) == 0);
                end
            end
            else
            begin
                before_n = raw_pending_q.size();
                if (pick < 20)
                    gen_broken();
                else
                    gen_string($urandom_range(19) == 0);
                made += raw_pending_q.size() - before_n;
            end
        end
        wait_accepted();
    endtask

    initial
    begin
        logic [7:0] esc_list[9];
        esc_list = '{CH_N, CH_R, CH_T, CH_B, CH_F, CH_LPAREN, CH_RPAREN, CH_BSLASH, 8'h71};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored idle byte, then an opening byte that is also last.
        push_req(8'h78, 1'b0);
        push_req(CH_LPAREN, 1'b1);
        // Extremes, every escape letter plus an unknown one, continuations.
        push_req(CH_LPAREN, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'hFF, 1'b0);
        foreach (esc_list[i])
        begin
            push_req(CH_BSLASH, 1'b0);
            push_req(esc_list[i], 1'b0);
        end
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_CR, 1'b0);
        push_req(CH_LF, 1'b0);
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_CR, 1'b0);
        push_req(8'h5A, 1'b0);
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_LF, 1'b0);
        push_req(CH_LPAREN, 1'b0);
        push_req(CH_RPAREN, 1'b0);
        // Three digits that overflow a byte, a flush before a plain byte,
        // and a flush before the closing parenthesis, which is also last.
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_SEVEN, 1'b0);
        push_req(CH_SEVEN, 1'b0);
        push_req(CH_SEVEN, 1'b0);
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_ZERO | 8'd4, 1'b0);
        push_req(8'h78, 1'b0);
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_ZERO | 8'd5, 1'b0);
        push_req(CH_ZERO | 8'd6, 1'b0);
        push_req(CH_RPAREN, 1'b1);
        // Trailing backslash on the last byte, then a pending octal at the end.
        push_req(CH_LPAREN, 1'b0);
        push_req(CH_BSLASH, 1'b1);
        push_req(CH_LPAREN, 1'b0);
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_ZERO | 8'd3, 1'b1);
        wait_accepted();

        // Random phases, one idle mix each.
        run_random(0, 0, 450);
        run_random(87, 0, 450);
        run_random(0, 87, 450);
        run_random(11, 11, 450);

        // Back-pressure: a long receiver hold-off while the sender streams.
        holdoff_ask <= 1'b1;
        run_random(0, 0, 150);

        // Deep nesting behind a drain pause: the opening byte waits until
        // every predicted result is out, then the string climbs and unwinds.
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        push_req(CH_LPAREN, 1'b0, 1'b1);
        repeat (12)
            push_req(CH_LPAREN, 1'b0);
        repeat (13)
            push_req(CH_RPAREN, 1'b0);
        wait_accepted();

        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests: directed escapes, four idle mixes, a long hold-off",
            req_count);
        $display("and a nesting peak of %0d; %0d results checked, %0d mismatches",
            peak_nest, res_count, err_count);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ls_unesc_pkg.sv
hw/rtl/literal_string_unescaper.sv
tb/literal_string_unescaper_test.sv
